// ===== hw/rtl/schrage_pkg.sv =====
// ---------------------------------------------------------------------------
// Schrage scheduler package
// Shared widths, the sequencer state type and the saturating time add.
// ---------------------------------------------------------------------------
package schrage_pkg;

    localparam int FIELD_W    = 16;            // width of each time field on the input
    localparam int IN_DATA_W  = 3 * FIELD_W;   // release, processing, delivery
    localparam int OUT_W      = 23;            // schedule time and makespan width
    localparam int OUT_DATA_W = 24;            // makespan padded to whole bytes

    localparam logic [OUT_W-1:0] SAT_MAX = {OUT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,    // take jobs into the store
        ST_SCAN,    // sweep the stored jobs for the next pick
        ST_COMMIT,  // mark the pick done and advance time
        ST_MAXUP,   // fold completion plus delivery into the running maximum
        ST_DONE     // hand the makespan to the output register
    } sched_state_t;

    // Add two schedule times, clamping at the top of the 23-bit range.
    function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] a,
                                                 input logic [OUT_W-1:0] b);
        logic [OUT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[OUT_W] ? SAT_MAX : sum[OUT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/schrage_makespan_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// Schrage makespan scheduler
// Stores jobs (release, processing, delivery) and, on the last beat of a set,
// runs Schrage's rule over them and returns the makespan.
// Load: one job beat per cycle while loading; not ready while a set schedules.
// Schedule: each pass sweeps the N stored jobs through the RAM read port,
// then commits the pick and, if a job was picked, updates the maximum; at
// most 2N passes run after the last beat, then DONE hands over the result.
// Reset (rst_n low, asynchronous) empties the set and the output register;
// the job RAM itself is never cleared, only entries of the current set are read.
// ---------------------------------------------------------------------------
module schrage_makespan_scheduler_unit
    import schrage_pkg::*;
#(
    parameter int MAX_JOBS   = 64,
    parameter int TIME_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // job beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] release_time, [31:16] processing_time,
                                             // [47:32] delivery_time
    input  logic                  s_tlast,   // last_job
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [22:0] makespan, [23] zero pad
    output logic                  m_tuser    // overflow
);

    // Stored field width: time fields keep only their low SW bits (TIME_WIDTH, at most FIELD_W).
    localparam int SW = (TIME_WIDTH < FIELD_W) ? TIME_WIDTH : FIELD_W;
    localparam int IW = $clog2(MAX_JOBS);       // RAM address width
    localparam int CW = $clog2(MAX_JOBS + 1);   // job count, holds MAX_JOBS itself
    localparam int RW = 3 * SW + 1;             // {done, delivery, processing, release}

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_JOBS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sched_state_t   state_reg, state_next;

    logic [CW-1:0]  count_reg, count_next;       // jobs held in this set
    logic [CW-1:0]  left_reg, left_next;         // jobs not yet scheduled
    logic           ovf_reg, ovf_next;           // a job of this set was dropped
    logic [OUT_W-1:0] time_reg, time_next;       // schedule clock
    logic [OUT_W-1:0] max_reg, max_next;         // running makespan

    logic [CW-1:0]  scan_idx_reg, scan_idx_next; // next RAM address to read
    logic           pend_reg, pend_next;         // read data arrives this cycle
    logic [IW-1:0]  pend_idx_reg, pend_idx_next; // index of that read

    logic           found_reg, found_next;       // a released job seen this pass
    logic           have_min_reg, have_min_next; // an unscheduled job seen this pass
    logic [IW-1:0]  best_idx_reg, best_idx_next;
    logic [SW-1:0]  best_rel_reg, best_rel_next;
    logic [SW-1:0]  best_proc_reg, best_proc_next;
    logic [SW-1:0]  best_del_reg, best_del_next;
    logic [SW-1:0]  min_rel_reg, min_rel_next;

    logic           m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_span_reg, m_span_next;
    logic           m_ovf_reg, m_ovf_next;

    // ------------------------------------------------------------------
    // Job RAM
    // ------------------------------------------------------------------
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic [RW-1:0]  ram_wdata;
    logic [RW-1:0]  ram_rdata;

    schrage_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    // Fields of the entry read back during a sweep
    logic          rd_done;
    logic [SW-1:0] rd_rel, rd_proc, rd_del;

    assign rd_rel  = ram_rdata[SW-1:0];
    assign rd_proc = ram_rdata[2*SW-1:SW];
    assign rd_del  = ram_rdata[3*SW-1:2*SW];
    assign rd_done = ram_rdata[3*SW];

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    logic in_beat;     // a job beat is taken this cycle
    logic store_room;  // the RAM still has a free entry
    logic issue;       // a RAM read goes out this cycle
    logic out_free;    // the output register can take a result
    logic [CW-1:0] count_stored;

    assign s_tready     = (state_reg == ST_LOAD);
    assign in_beat      = s_tvalid && s_tready;
    assign store_room   = (count_reg < COUNT_MAX);
    assign count_stored = store_room ? (count_reg + CW'(1)) : count_reg;
    assign issue        = (state_reg == ST_SCAN) && (scan_idx_reg != count_reg);
    assign out_free     = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_beat && s_tlast)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // sweep finished once every read has been issued and folded in
                if (!issue && !pend_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = found_reg ? ST_MAXUP : ST_SCAN;
            end
            ST_MAXUP:
            begin
                state_next = (left_reg == '0) ? ST_DONE : ST_SCAN;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM port control
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] finish_time;

    assign finish_time = sat_add(time_reg, OUT_W'(best_del_reg));

    always_comb
    begin
        count_next     = count_reg;
        left_next      = left_reg;
        ovf_next       = ovf_reg;
        time_next      = time_reg;
        max_next       = max_reg;

        scan_idx_next  = '0;
        pend_next      = issue;
        pend_idx_next  = scan_idx_reg[IW-1:0];

        // pass accumulators only live inside a sweep
        found_next     = 1'b0;
        have_min_next  = 1'b0;
        best_idx_next  = best_idx_reg;
        best_rel_next  = best_rel_reg;
        best_proc_next = best_proc_reg;
        best_del_next  = best_del_reg;
        min_rel_next   = min_rel_reg;

        m_valid_next   = m_valid_reg && !m_tready;
        m_span_next    = m_span_reg;
        m_ovf_next     = m_ovf_reg;

        ram_we         = 1'b0;
        ram_waddr      = count_reg[IW-1:0];
        ram_wdata      = {1'b0, s_tdata[2*FIELD_W +: SW], s_tdata[FIELD_W +: SW],
                          s_tdata[SW-1:0]};

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    // store while there is room, otherwise drop and flag
                    ram_we     = store_room;
                    count_next = count_stored;
                    ovf_next   = ovf_reg || !store_room;
                    if (s_tlast)
                    begin
                        left_next = count_stored;
                        time_next = '0;
                        max_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = issue ? (scan_idx_reg + CW'(1)) : scan_idx_reg;
                found_next    = found_reg;
                have_min_next = have_min_reg;
                if (pend_reg && !rd_done)
                begin
                    if (!have_min_reg || (rd_rel < min_rel_reg))
                    begin
                        min_rel_next  = rd_rel;
                        have_min_next = 1'b1;
                    end
                    // strict compare keeps the lowest index on equal delivery
                    if ((OUT_W'(rd_rel) <= time_reg) &&
                        (!found_reg || (rd_del > best_del_reg)))
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = pend_idx_reg;
                        best_rel_next  = rd_rel;
                        best_proc_next = rd_proc;
                        best_del_next  = rd_del;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (found_reg)
                begin
                    // write the pick back with its done mark set
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = {1'b1, best_del_reg, best_proc_reg, best_rel_reg};
                    time_next = sat_add(time_reg, OUT_W'(best_proc_reg));
                    left_next = left_reg - CW'(1);
                end
                else
                begin
                    // nothing released yet: jump to the earliest release
                    time_next = OUT_W'(min_rel_reg);
                end
            end
            ST_MAXUP:
            begin
                if (finish_time > max_reg)
                begin
                    max_next = finish_time;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_span_next  = max_reg;
                    m_ovf_next   = ovf_reg;
                    // clear the set for the next run of jobs
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    time_next    = '0;
                    max_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            left_reg     <= '0;
            ovf_reg      <= 1'b0;
            time_reg     <= '0;
            max_reg      <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            have_min_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            left_reg     <= left_next;
            ovf_reg      <= ovf_next;
            time_reg     <= time_next;
            max_reg      <= max_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            have_min_reg <= have_min_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_rel_reg  <= best_rel_next;
        best_proc_reg <= best_proc_next;
        best_del_reg  <= best_del_next;
        min_rel_reg   <= min_rel_next;
        m_span_reg    <= m_span_next;
        m_ovf_reg     <= m_ovf_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_W){1'b0}}, m_span_reg};
    assign m_tuser  = m_ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the job count never runs past the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("job count beyond store depth");

    // unscheduled jobs never outnumber stored jobs while scheduling
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (left_reg <= count_reg))
        else $error("more jobs left than stored");

    // the last beat of a set starts a sweep
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_SCAN))
        else $error("last job did not start the schedule");

    // no write-back can overlap a sweep's reads
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("RAM write during sweep");

endmodule

// ===== hw/rtl/schrage_ram.sv =====
// ---------------------------------------------------------------------------
// Schrage scheduler RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module schrage_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
